// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle assertion failed");

`endif

// ===== rtl/core/gdu_pkg.sv =====
// ----------------------------------------------------------------------------
// gdu_pkg
// Types, constants and the base32 symbol map for the geohash decoder unit.
// ----------------------------------------------------------------------------
package gdu_pkg;

  localparam int GDU_MAX_CHARS = 12;
  localparam int GDU_ACC_W     = 30;
  localparam int GDU_IDX_W     = 4;

  typedef logic [1:0]           status_t;
  typedef logic [GDU_IDX_W-1:0] idx_t;
  typedef logic [GDU_ACC_W-1:0] acc_t;

  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_BAD_CHAR = 2'd1;
  localparam status_t STATUS_TOO_LONG = 2'd2;

  // Returns {valid, value}; valid is low for characters outside the alphabet.
  function automatic logic [5:0] symbol_lookup(logic [7:0] ch);
    logic [7:0] lc;
    logic [5:0] res;
    lc = ch;
    if (ch >= "A" && ch <= "Z") begin
      lc = ch | 8'h20;
    end
    unique case (lc)
      "0": res = {1'b1, 5'd0};
      "1": res = {1'b1, 5'd1};
      "2": res = {1'b1, 5'd2};
      "3": res = {1'b1, 5'd3};
      "4": res = {1'b1, 5'd4};
      "5": res = {1'b1, 5'd5};
      "6": res = {1'b1, 5'd6};
      "7": res = {1'b1, 5'd7};
      "8": res = {1'b1, 5'd8};
      "9": res = {1'b1, 5'd9};
      "b": res = {1'b1, 5'd10};
      "c": res = {1'b1, 5'd11};
      "d": res = {1'b1, 5'd12};
      "e": res = {1'b1, 5'd13};
      "f": res = {1'b1, 5'd14};
      "g": res = {1'b1, 5'd15};
      "h": res = {1'b1, 5'd16};
      "j": res = {1'b1, 5'd17};
      "k": res = {1'b1, 5'd18};
      "m": res = {1'b1, 5'd19};
      "n": res = {1'b1, 5'd20};
      "p": res = {1'b1, 5'd21};
      "q": res = {1'b1, 5'd22};
      "r": res = {1'b1, 5'd23};
      "s": res = {1'b1, 5'd24};
      "t": res = {1'b1, 5'd25};
      "u": res = {1'b1, 5'd26};
      "v": res = {1'b1, 5'd27};
      "w": res = {1'b1, 5'd28};
      "x": res = {1'b1, 5'd29};
      "y": res = {1'b1, 5'd30};
      "z": res = {1'b1, 5'd31};
      default: res = 6'd0;
    endcase
    return res;
  endfunction

  // Centre of the cell given k received bits b, with the sign bit offset applied.
  function automatic logic [31:0] cell_center(acc_t b, logic [4:0] k);
    logic [5:0]  sh_b;
    logic [5:0]  sh_h;
    logic [32:0] tmp;
    sh_b = 6'd32 - {1'b0, k};
    sh_h = 6'd31 - {1'b0, k};
    tmp  = ({3'b000, b} << sh_b) | (33'd1 << sh_h);
    return tmp[31:0] ^ 32'h8000_0000;
  endfunction

endpackage

// ===== rtl/core/geohash_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// geohash_decoder_unit
// Decodes a geohash delivered one character per transfer into a cell centre.
// ----------------------------------------------------------------------------
// The unit accepts one character per clock cycle unless a final character
// stalls, as described below. Each character passes an input register and is
// folded into the longitude and latitude accumulators as it leaves that
// register; the character flagged as last also loads the result register,
// which presents the result and holds it until its own transfer. The result
// register lets the next geohash stream in while a result waits; only a final
// character stalls in the input register until the earlier result is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module geohash_decoder_unit #(
  parameter int MAX_CHARS = gdu_pkg::GDU_MAX_CHARS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_code_char,
  input  logic                   in_last_char,
  output logic                   out_valid,
  input  logic                   out_ready,
  output gdu_pkg::status_t       out_status,
  output logic signed [31:0]     out_latitude,
  output logic signed [31:0]     out_longitude,
  output gdu_pkg::idx_t          out_chars_used
);

  import gdu_pkg::*;

  localparam idx_t MAX_IDX = idx_t'(MAX_CHARS);

  logic        s1_valid_r, s1_valid_nxt;
  logic [7:0]  s1_char_r;
  logic        s1_last_r;
  acc_t        lon_acc_r, lon_acc_nxt;
  acc_t        lat_acc_r, lat_acc_nxt;
  idx_t        idx_r, idx_nxt;
  status_t     err_r, err_nxt;
  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r;
  logic [31:0] out_lat_r, out_lon_r;
  idx_t        out_used_r;

  logic        fire;
  logic        in_xfer;
  logic [5:0]  sym;
  logic [5:0]  total;
  logic [5:0]  total_p1;
  logic [4:0]  lon_bits, lat_bits;

  assign fire     = s1_valid_r && (!s1_last_r || !out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || fire;
  assign in_xfer  = in_valid && in_ready;
  assign sym      = symbol_lookup(s1_char_r);

  always_comb begin
    lon_acc_nxt = lon_acc_r;
    lat_acc_nxt = lat_acc_r;
    idx_nxt     = idx_r;
    err_nxt     = err_r;
    if (err_r != STATUS_BAD_CHAR) begin
      if (idx_r >= MAX_IDX) begin
        err_nxt = STATUS_TOO_LONG;
      end else if (!sym[5]) begin
        err_nxt = STATUS_BAD_CHAR;
      end else begin
        if (!idx_r[0]) begin
          lon_acc_nxt = {lon_acc_r[GDU_ACC_W-4:0], sym[4], sym[2], sym[0]};
          lat_acc_nxt = {lat_acc_r[GDU_ACC_W-3:0], sym[3], sym[1]};
        end else begin
          lat_acc_nxt = {lat_acc_r[GDU_ACC_W-4:0], sym[4], sym[2], sym[0]};
          lon_acc_nxt = {lon_acc_r[GDU_ACC_W-3:0], sym[3], sym[1]};
        end
        idx_nxt = idx_r + idx_t'(1);
      end
    end
  end

  assign total    = ({2'b00, idx_nxt} << 2) + {2'b00, idx_nxt};
  assign total_p1 = total + 6'd1;
  assign lon_bits = total_p1[5:1];
  assign lat_bits = total[5:1];

  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !fire);
  assign out_valid_nxt = (fire && s1_last_r) || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lon_acc_r   <= '0;
      lat_acc_r   <= '0;
      idx_r       <= '0;
      err_r       <= STATUS_OK;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        if (s1_last_r) begin
          lon_acc_r <= '0;
          lat_acc_r <= '0;
          idx_r     <= '0;
          err_r     <= STATUS_OK;
        end else begin
          lon_acc_r <= lon_acc_nxt;
          lat_acc_r <= lat_acc_nxt;
          idx_r     <= idx_nxt;
          err_r     <= err_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_char_r <= in_code_char;
      s1_last_r <= in_last_char;
    end
    if (fire && s1_last_r) begin
      out_status_r <= err_nxt;
      if (err_nxt == STATUS_BAD_CHAR) begin
        out_lat_r  <= '0;
        out_lon_r  <= '0;
        out_used_r <= '0;
      end else begin
        out_lat_r  <= cell_center(lat_acc_nxt, lat_bits);
        out_lon_r  <= cell_center(lon_acc_nxt, lon_bits);
        out_used_r <= idx_nxt;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_latitude   = out_lat_r;
  assign out_longitude  = out_lon_r;
  assign out_chars_used = out_used_r;

  `ASSERT_SAME(a_idx_bound, clk, rst_n, 1'b1, idx_r <= MAX_IDX)
  `ASSERT_NEXT(a_last_gives_result, clk, rst_n, fire && s1_last_r, out_valid_r)
  `ASSERT_SAME(a_bad_char_zero, clk, rst_n, out_valid_r && out_status_r == STATUS_BAD_CHAR,
    out_lat_r == '0 && out_lon_r == '0 && out_used_r == '0)
  `ASSERT_SAME(a_empty_stage_ready, clk, rst_n, !s1_valid_r, in_ready)

endmodule
